### src/cv3_pkg.sv
// Package for the 3x3 convolution block: sizes, register codes, reset values,
// the pipeline structs and the row multiply-accumulate function.
// No dependencies.
`timescale 1ns / 1ps

package cv3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_SIZE   = 3;

    // counter widths follow from the frame limits
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WSZ_W = $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W = $clog2(MAX_HEIGHT + 1);

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 8;
    localparam int KROW_W     = 3 * COEF_W;
    localparam int SIZE_W     = 11;
    localparam int POS_W      = 10;
    localparam int VAL_W      = 20;
    localparam int PROD_W     = COEF_W + PIX_W + 1;
    localparam int RSUM_W     = PROD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [KROW_W-1:0] KERN_TOP_RST = 24'h00FF00;
    localparam logic [KROW_W-1:0] KERN_MID_RST = 24'hFF05FF;
    localparam logic [KROW_W-1:0] KERN_BOT_RST = 24'h00FF00;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERN_TOP     = 3'd0,
        CFG_KERN_MID     = 3'd1,
        CFG_KERN_BOT     = 3'd2,
        CFG_FRAME_WIDTH  = 3'd3,
        CFG_FRAME_HEIGHT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [KROW_W-1:0] kern_top;
        logic [KROW_W-1:0] kern_mid;
        logic [KROW_W-1:0] kern_bot;
        logic [WSZ_W-1:0]  width;
        logic [HSZ_W-1:0]  height;
    } cfg_t;

    // line buffer access issued when a pixel is taken
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] pixel;
    } lbuf_req_t;

    // first pipeline stage: one taken pixel or flush transaction
    typedef struct packed {
        logic             is_pix;
        logic             emit;
        logic             interior;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] pixel;
    } s1_t;

    typedef struct packed {
        logic s2_valid;
        logic s2_adv;
    } dp_stat_t;

    function automatic logic signed [RSUM_W-1:0] row_sum(
        input logic [KROW_W-1:0] k,
        input logic [PIX_W-1:0]  l,
        input logic [PIX_W-1:0]  c,
        input logic [PIX_W-1:0]  r
    );
        logic signed [COEF_W-1:0] kl;
        logic signed [COEF_W-1:0] kc;
        logic signed [COEF_W-1:0] kr;
        logic signed [PROD_W-1:0] pl;
        logic signed [PROD_W-1:0] pc;
        logic signed [PROD_W-1:0] pr;
        kl = k[COEF_W-1:0];
        kc = k[2*COEF_W-1:COEF_W];
        kr = k[3*COEF_W-1:2*COEF_W];
        pl = kl * $signed({1'b0, l});
        pc = kc * $signed({1'b0, c});
        pr = kr * $signed({1'b0, r});
        return {{(RSUM_W-PROD_W){pl[PROD_W-1]}}, pl}
             + {{(RSUM_W-PROD_W){pc[PROD_W-1]}}, pc}
             + {{(RSUM_W-PROD_W){pr[PROD_W-1]}}, pr};
    endfunction

endpackage

### src/cv3_if.sv
// Channel interfaces of the 3x3 convolution block: pixel stream, result
// stream and register write channel. Depends on cv3_pkg.
`timescale 1ns / 1ps

interface cv3_pix_if import cv3_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, action, pixel, input ready);
    modport sink (input valid, action, pixel, output ready);
endinterface

interface cv3_res_if import cv3_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [POS_W-1:0]        result_row;
    logic [POS_W-1:0]        result_col;
    logic signed [VAL_W-1:0] value;
    logic                    frame_end;

    modport source (output valid, result_row, result_col, value, frame_end, input ready);
    modport sink (input valid, result_row, result_col, value, frame_end, output ready);
endinterface

interface cv3_cfg_if import cv3_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/cv3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents. No dependencies.
`timescale 1ns / 1ps

module cv3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/cv3_cfg.sv
// Configuration registers: kernel rows and frame size, clamped on write.
// Depends on cv3_pkg and cv3_if.
`timescale 1ns / 1ps

module cv3_cfg import cv3_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    cv3_cfg_if.sink   cfg,
    output cfg_t      regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    function automatic logic [WSZ_W-1:0] clamp_w(input logic [SIZE_W-1:0] v);
        if (v < SIZE_W'(MIN_SIZE))
        begin
            return WSZ_W'(MIN_SIZE);
        end
        if (v > SIZE_W'(MAX_WIDTH))
        begin
            return WSZ_W'(MAX_WIDTH);
        end
        return WSZ_W'(v);
    endfunction

    function automatic logic [HSZ_W-1:0] clamp_h(input logic [SIZE_W-1:0] v);
        if (v < SIZE_W'(MIN_SIZE))
        begin
            return HSZ_W'(MIN_SIZE);
        end
        if (v > SIZE_W'(MAX_HEIGHT))
        begin
            return HSZ_W'(MAX_HEIGHT);
        end
        return HSZ_W'(v);
    endfunction

    assign cfg.ready = 1'b1;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_KERN_TOP:     regs_next.kern_top = cfg.data[KROW_W-1:0];
                CFG_KERN_MID:     regs_next.kern_mid = cfg.data[KROW_W-1:0];
                CFG_KERN_BOT:     regs_next.kern_bot = cfg.data[KROW_W-1:0];
                CFG_FRAME_WIDTH:  regs_next.width = clamp_w(cfg.data[SIZE_W-1:0]);
                CFG_FRAME_HEIGHT: regs_next.height = clamp_h(cfg.data[SIZE_W-1:0]);
                default:          regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.kern_top <= KERN_TOP_RST;
            regs_reg.kern_mid <= KERN_MID_RST;
            regs_reg.kern_bot <= KERN_BOT_RST;
            regs_reg.width    <= WSZ_W'(MAX_WIDTH);
            regs_reg.height   <= HSZ_W'(MAX_HEIGHT);
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

### src/cv3_ctrl.sv
// Position tracking for input and output, frame end and flush handling,
// and the first pipeline stage. Depends on cv3_pkg.
`timescale 1ns / 1ps

module cv3_ctrl import cv3_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             regs,
    input  logic             acc,
    input  logic             action,
    input  logic [PIX_W-1:0] pixel,
    input  logic             s1_adv,
    output lbuf_req_t        lbuf,
    output s1_t              s1,
    output logic             s1_valid
);

    logic [HSZ_W-1:0] in_row_reg,  in_row_next;
    logic [COL_W-1:0] in_col_reg,  in_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic             s1_valid_reg, s1_valid_next;
    s1_t              s1_reg, s1_next;

    logic             frame_in;
    logic             take_pix;
    logic             take_flush;
    logic             gives;
    logic             emit;
    logic [COL_W:0]   w_ext;
    logic [ROW_W:0]   h_ext;
    logic [COL_W:0]   in_col_inc;
    logic             in_wrap;
    logic [COL_W:0]   out_col_inc;
    logic [ROW_W:0]   out_row_inc;
    logic             out_wrap;
    logic [ROW_W:0]   out_row_new;
    logic             done;
    logic             last;
    logic             interior;

    assign w_ext = (COL_W+1)'(regs.width);
    assign h_ext = (ROW_W+1)'(regs.height);

    assign frame_in   = in_row_reg >= regs.height;
    assign take_pix   = acc && (action == ACT_PIXEL) && !frame_in;
    assign take_flush = acc && (action == ACT_FLUSH) && frame_in;
    assign gives      = (in_row_reg >= HSZ_W'(2))
                      || ((in_row_reg == HSZ_W'(1)) && (in_col_reg != '0));
    assign emit       = take_flush || (take_pix && gives);

    assign in_col_inc  = {1'b0, in_col_reg} + 1'b1;
    assign in_wrap     = in_col_inc >= w_ext;
    assign out_col_inc = {1'b0, out_col_reg} + 1'b1;
    assign out_row_inc = {1'b0, out_row_reg} + 1'b1;
    assign out_wrap    = out_col_inc >= w_ext;
    assign out_row_new = out_wrap ? out_row_inc : {1'b0, out_row_reg};
    assign done        = out_row_new >= h_ext;
    assign last        = (out_row_inc >= h_ext) && out_wrap;
    assign interior    = take_pix && (out_row_reg != '0) && (out_row_inc < h_ext)
                       && (out_col_reg != '0) && (out_col_inc < w_ext);

    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (take_pix)
        begin
            if (in_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_inc[COL_W-1:0];
            end
        end
        if (emit)
        begin
            out_col_next = out_wrap ? '0 : out_col_inc[COL_W-1:0];
            out_row_next = out_row_new[ROW_W-1:0];
            // last position delivered: the next pixel opens a new frame
            if (done)
            begin
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
            end
        end
    end

    always_comb
    begin
        s1_next          = s1_reg;
        s1_next.is_pix   = take_pix;
        s1_next.emit     = emit;
        s1_next.interior = interior;
        s1_next.last     = last;
        s1_next.row      = out_row_reg;
        s1_next.col      = out_col_reg;
        s1_next.addr     = in_col_reg;
        s1_next.pixel    = pixel;

        if (take_pix || take_flush)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_pix || take_flush)
        begin
            s1_reg <= s1_next;
        end
    end

    assign lbuf.en    = take_pix;
    assign lbuf.addr  = in_col_reg;
    assign lbuf.pixel = pixel;
    assign s1         = s1_reg;
    assign s1_valid   = s1_valid_reg;

endmodule

### src/cv3_dp.sv
// Window registers, row multiply-accumulate stage and output register.
// Depends on cv3_pkg and cv3_if.
`timescale 1ns / 1ps

module cv3_dp import cv3_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             regs,
    input  s1_t              s1,
    input  logic             s1_valid,
    input  logic [PIX_W-1:0] top,
    input  logic [PIX_W-1:0] mid,
    output logic             s1_adv,
    output dp_stat_t         stat,
    cv3_res_if.source        res
);

    logic [PIX_W-1:0]         win_reg [6];
    logic signed [RSUM_W-1:0] rs_top, rs_mid, rs_bot;
    logic signed [RSUM_W-1:0] rs_reg [3];
    logic [ROW_W-1:0]         s2_row_reg;
    logic [COL_W-1:0]         s2_col_reg;
    logic                     s2_last_reg;
    logic                     s2_valid_reg, s2_valid_next;
    logic                     s2_adv;
    logic                     s2_load;
    logic                     out_valid_reg, out_valid_next;
    logic [POS_W-1:0]         out_row_reg;
    logic [POS_W-1:0]         out_col_reg;
    logic signed [VAL_W-1:0]  out_value_reg, out_value_next;
    logic                     out_last_reg;

    assign s2_adv  = s2_valid_reg && (!out_valid_reg || res.ready);
    // a transaction with no result only needs to update the window
    assign s1_adv  = s1_valid && (!s1.emit || !s2_valid_reg || s2_adv);
    assign s2_load = s1_adv && s1.emit;

    assign rs_top = row_sum(regs.kern_top, win_reg[0], win_reg[3], top);
    assign rs_mid = row_sum(regs.kern_mid, win_reg[1], win_reg[4], mid);
    assign rs_bot = row_sum(regs.kern_bot, win_reg[2], win_reg[5], s1.pixel);

    assign out_value_next = {{(VAL_W-RSUM_W){rs_reg[0][RSUM_W-1]}}, rs_reg[0]}
                          + {{(VAL_W-RSUM_W){rs_reg[1][RSUM_W-1]}}, rs_reg[1]}
                          + {{(VAL_W-RSUM_W){rs_reg[2][RSUM_W-1]}}, rs_reg[2]};

    always_comb
    begin
        if (s2_load)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end

        if (s2_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv && s1.is_pix)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top;
                win_reg[4] <= mid;
                win_reg[5] <= s1.pixel;
            end
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            // border positions and flushed positions give zero
            rs_reg[0]   <= s1.interior ? rs_top : '0;
            rs_reg[1]   <= s1.interior ? rs_mid : '0;
            rs_reg[2]   <= s1.interior ? rs_bot : '0;
            s2_row_reg  <= s1.row;
            s2_col_reg  <= s1.col;
            s2_last_reg <= s1.last;
        end
        if (s2_adv)
        begin
            out_row_reg   <= POS_W'(s2_row_reg);
            out_col_reg   <= POS_W'(s2_col_reg);
            out_value_reg <= out_value_next;
            out_last_reg  <= s2_last_reg;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.result_row = out_row_reg;
    assign res.result_col = out_col_reg;
    assign res.value      = out_value_reg;
    assign res.frame_end  = out_last_reg;

    assign stat.s2_valid = s2_valid_reg;
    assign stat.s2_adv   = s2_adv;

endmodule

### src/conv3x3_zero_border.sv
// Top level of the streaming 3x3 convolution with zero border.
// Depends on cv3_pkg, cv3_if, cv3_ram, cv3_cfg, cv3_ctrl and cv3_dp.
`timescale 1ns / 1ps

// Takes one pixel per clock in raster order while the result side does not
// stall the pipeline, and returns one signed result per frame position, also
// in raster order, one per clock when the result side keeps ready high. The
// pixel that completes a 3x3 window is registered with its line buffer reads,
// then its three row multiply-accumulates, then the final add into the output
// register. Results trail the pixel stream by frame_width+1 positions, so
// after the last pixel of a frame send frame_width+1 flush transactions to
// drain the frame; border positions give 0 and the last one carries
// frame_end. The two rows above are held in two 1024x8 RAMs with one write
// and one read port each; no clearing pass is needed after reset. Write the
// registers only while the block is idle.
module conv3x3_zero_border import cv3_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    cv3_pix_if.sink   pix,
    cv3_res_if.source res,
    cv3_cfg_if.sink   cfg
);

    cfg_t             regs;
    lbuf_req_t        lbuf;
    s1_t              s1;
    logic             s1_valid;
    logic             s1_adv;
    dp_stat_t         dstat;
    logic             acc;
    logic             two_we;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;

    assign pix.ready = !s1_valid || s1_adv;
    assign acc       = pix.valid && pix.ready;
    assign two_we    = s1_adv && s1.is_pix;

    cv3_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    cv3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .regs     (regs),
        .acc      (acc),
        .action   (pix.action),
        .pixel    (pix.pixel),
        .s1_adv   (s1_adv),
        .lbuf     (lbuf),
        .s1       (s1),
        .s1_valid (s1_valid)
    );

    cv3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .clk   (clk),
        .we    (lbuf.en),
        .waddr (lbuf.addr),
        .wdata (lbuf.pixel),
        .re    (lbuf.en),
        .raddr (lbuf.addr),
        .rdata (mid)
    );

    cv3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .clk   (clk),
        .we    (two_we),
        .waddr (s1.addr),
        .wdata (mid),
        .re    (lbuf.en),
        .raddr (lbuf.addr),
        .rdata (top)
    );

    cv3_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .regs     (regs),
        .s1       (s1),
        .s1_valid (s1_valid),
        .top      (top),
        .mid      (mid),
        .s1_adv   (s1_adv),
        .stat     (dstat),
        .res      (res)
    );

    // the delayed row write never lands on the column being read
    a_lbuf_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (lbuf.en && two_we) |-> (lbuf.addr != s1.addr))
        else $error("line buffer write collides with read");

    // a flush transaction only enters the pipeline to give a result
    a_flush_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && !s1.is_pix) |-> s1.emit)
        else $error("flush transaction without result in pipeline");

    // a stalled accumulate stage keeps its transaction
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (dstat.s2_valid && !dstat.s2_adv) |=> dstat.s2_valid)
        else $error("accumulate stage dropped a transaction");

    // a new result comes only from the accumulate stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !$past(res.valid)) |-> $past(dstat.s2_valid))
        else $error("result appeared without a source transaction");

endmodule
